// ===== rtl/core/tlik_pkg.sv =====
`timescale 1ns / 1ps

package tlik_pkg;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned LinkW    = 15;

  localparam logic [CfgIdxW-1:0] RegUpperLink = 8'd0;
  localparam logic [CfgIdxW-1:0] RegLowerLink = 8'd1;

  localparam logic [LinkW-1:0] UpperLinkReset = 15'd2048;
  localparam logic [LinkW-1:0] LowerLinkReset = 15'd2560;

  // Square root and angle datapath.
  localparam int unsigned SqrtSteps   = 32;
  localparam int unsigned CordicSteps = 21;
  localparam int unsigned AngLat      = CordicSteps + 4;
  localparam int unsigned AngFrac     = 16;
  localparam int unsigned NormExp     = 32;
  localparam int unsigned VecXW       = 34;
  localparam int unsigned VecYW       = 33;
  localparam int unsigned CrdW        = 36;
  localparam int unsigned ZW          = 26;
  localparam int unsigned AngW        = 24;
  localparam int unsigned AtanW       = 22;

  localparam logic [AngW-1:0]      Ang180 = 24'd11796480;
  localparam logic signed [ZW-1:0] Ang90  = 26'sd5898240;
  localparam logic [7:0]           DegMax = 8'd180;

  typedef struct packed {
    logic signed [15:0] reach_distance;
    logic signed [15:0] height_offset;
  } tlik_in_t;

  typedef struct packed {
    logic [7:0] upper_joint_deg;
    logic       upper_valid;
    logic [7:0] lower_joint_deg;
    logic       lower_valid;
  } tlik_out_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } tlik_sqrt_t;

  typedef struct packed {
    logic signed [CrdW-1:0] x;
    logic signed [CrdW-1:0] y;
    logic signed [ZW-1:0]   z;
  } tlik_cordic_t;

  // atan(2^-i) in units of 2^-16 degree, rounded to nearest.
  function automatic logic [AtanW-1:0] tlik_atan(int unsigned idx);
    logic [AtanW-1:0] r;
    case (idx)
      0:       r = 22'd2949120;
      1:       r = 22'd1740967;
      2:       r = 22'd919879;
      3:       r = 22'd466945;
      4:       r = 22'd234379;
      5:       r = 22'd117304;
      6:       r = 22'd58666;
      7:       r = 22'd29335;
      8:       r = 22'd14668;
      9:       r = 22'd7334;
      10:      r = 22'd3667;
      11:      r = 22'd1833;
      12:      r = 22'd917;
      13:      r = 22'd458;
      14:      r = 22'd229;
      15:      r = 22'd115;
      16:      r = 22'd57;
      17:      r = 22'd29;
      18:      r = 22'd14;
      19:      r = 22'd7;
      20:      r = 22'd4;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/tlik_sqrt_cell.sv =====
`timescale 1ns / 1ps

module tlik_sqrt_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  tlik_pkg::tlik_sqrt_t d_i,
  output tlik_pkg::tlik_sqrt_t q_o
);
  import tlik_pkg::*;

  // One result bit per cell, most significant first.
  localparam logic [63:0] Bit = 64'd1 << (62 - 2 * Idx);

  logic [63:0] trial;
  tlik_sqrt_t  data_d;
  tlik_sqrt_t  data_q;

  always_comb begin
    trial = d_i.root + Bit;
    if (d_i.rem >= trial) begin
      data_d.rem  = d_i.rem - trial;
      data_d.root = (d_i.root >> 1) + Bit;
    end else begin
      data_d.rem  = d_i.rem;
      data_d.root = d_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign q_o = data_q;

endmodule

// ===== rtl/core/tlik_cordic_cell.sv =====
`timescale 1ns / 1ps

module tlik_cordic_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  tlik_pkg::tlik_cordic_t d_i,
  output tlik_pkg::tlik_cordic_t q_o
);
  import tlik_pkg::*;

  localparam logic signed [ZW-1:0] Step = $signed({{(ZW-AtanW){1'b0}}, tlik_atan(Idx)});

  logic signed [CrdW-1:0] dx;
  logic signed [CrdW-1:0] dy;
  tlik_cordic_t           data_d;
  tlik_cordic_t           data_q;

  // Arithmetic shifts round toward minus infinity.
  always_comb begin
    dx = d_i.y >>> Idx;
    dy = d_i.x >>> Idx;
    if (!d_i.y[CrdW-1]) begin
      data_d.x = d_i.x + dx;
      data_d.y = d_i.y - dy;
      data_d.z = d_i.z + Step;
    end else begin
      data_d.x = d_i.x - dx;
      data_d.y = d_i.y + dy;
      data_d.z = d_i.z - Step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign q_o = data_q;

endmodule

// ===== rtl/core/tlik_angle.sv =====
`timescale 1ns / 1ps

module tlik_angle (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [tlik_pkg::VecXW-1:0]     px_i,
  input  logic        [tlik_pkg::VecYW-1:0]     py_i,
  output logic        [tlik_pkg::AngW-1:0]      ang_o
);
  import tlik_pkg::*;

  typedef struct packed {
    logic [VecYW-1:0]     x;
    logic [VecYW-1:0]     y;
    logic signed [ZW-1:0] z;
  } vec_t;

  localparam logic signed [ZW-1:0] Ang180Z = $signed({{(ZW-AngW){1'b0}}, Ang180});

  // Shifts both parts left by s bits if the larger one is below 2^lim.
  function automatic vec_t norm_step(vec_t v, int unsigned s, int unsigned lim);
    logic [VecYW-1:0] m;
    vec_t             r;
    m = (v.x > v.y) ? v.x : v.y;
    r = v;
    if (m < (VecYW'(1) << lim)) begin
      r.x = v.x << s;
      r.y = v.y << s;
    end
    return r;
  endfunction

  logic signed [VecXW-1:0] negx;
  vec_t                    pre_d;
  vec_t                    pre_q;
  vec_t                    nrm1_d;
  vec_t                    nrm1_q;
  vec_t                    nrm2_d;
  vec_t                    nrm2_q;
  tlik_cordic_t            stg [CordicSteps+1];
  logic [AngW-1:0]         ang_d;
  logic [AngW-1:0]         ang_q;

  // A vector in the left half plane is turned by -90 degrees first.
  always_comb begin
    negx = -px_i;
    if (px_i[VecXW-1]) begin
      pre_d.x = py_i;
      pre_d.y = negx[VecYW-1:0];
      pre_d.z = Ang90;
    end else begin
      pre_d.x = px_i[VecYW-1:0];
      pre_d.y = py_i;
      pre_d.z = '0;
    end
  end

  // Normalization brings the larger part into [2^32, 2^33).
  always_comb begin
    nrm1_d = norm_step(norm_step(norm_step(pre_q, 16, NormExp - 16), 8, NormExp - 8),
                       4, NormExp - 4);
    nrm2_d = norm_step(norm_step(norm_step(nrm1_q, 2, NormExp - 2), 1, NormExp - 1),
                       1, NormExp);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_q  <= pre_d;
      nrm1_q <= nrm1_d;
      nrm2_q <= nrm2_d;
      ang_q  <= ang_d;
    end
  end

  assign stg[0].x = $signed({{(CrdW-VecYW){1'b0}}, nrm2_q.x});
  assign stg[0].y = $signed({{(CrdW-VecYW){1'b0}}, nrm2_q.y});
  assign stg[0].z = nrm2_q.z;

  for (genvar k = 0; k < CordicSteps; k++) begin : g_cell
    tlik_cordic_cell #(.Idx(k)) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .d_i   (stg[k]),
      .q_o   (stg[k+1])
    );
  end

  always_comb begin
    if (stg[CordicSteps].z[ZW-1]) begin
      ang_d = '0;
    end else if (stg[CordicSteps].z > Ang180Z) begin
      ang_d = Ang180;
    end else begin
      ang_d = stg[CordicSteps].z[AngW-1:0];
    end
  end

  assign ang_o = ang_q;

endmodule

// ===== rtl/core/two_link_leg_inverse_kinematics.sv =====
`timescale 1ns / 1ps

// Inverse kinematics for a two-segment leg. A foot target (reach, height)
// enters on the in_* valid/ready channel; one result with both joint angles
// and their valid flags leaves on the out_* channel for every target.
// Segment lengths are written on the cfg_* channel (index 0 upper link,
// index 1 lower link, other indexes ignored); cfg_ready_o is always high.
// Write them only while no target is in flight.
// The datapath is a 62-stage pipeline: four stages of squares and products,
// two parallel rows of 32 square-root cells (one result bit each), three
// parallel rows of 21 CORDIC cells behind a three-stage prerotate and
// normalize front end, a clamp stage, then the degree and range check.
// Each result passes through all stages and then the output register, and
// one target is taken every cycle while the skid entry is empty.
// The output register is backed by a one-entry skid buffer, so in_ready_o
// only depends on registered state. When the receiver stalls, results fill
// the skid entry and then the whole pipeline freezes with its contents held;
// in_ready_o stays low from the skid fill through the cycle that drains it.
// Reset clears all valid state and sets the link lengths to 2048 and 2560.
module two_link_leg_inverse_kinematics (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  tlik_pkg::tlik_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tlik_pkg::tlik_out_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tlik_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tlik_pkg::CfgDataW-1:0]   cfg_data_i
);
  import tlik_pkg::*;

  localparam int unsigned PipeDepth = 4 + SqrtSteps + AngLat + 1;

  typedef struct packed {
    logic [30:0]        rx2;
    logic [30:0]        hy2;
    logic [29:0]        l1sq;
    logic [29:0]        l2sq;
    logic signed [15:0] hy;
    logic [15:0]        arx;
    logic               l1nz;
    logic               l2nz;
  } s1_t;

  typedef struct packed {
    logic [31:0]        b2;
    logic [29:0]        l1sq;
    logic [29:0]        l2sq;
    logic signed [33:0] n1;
    logic signed [33:0] n3;
    logic signed [15:0] hy;
    logic [15:0]        arx;
    logic               l1nz;
    logic               l2nz;
  } s2_t;

  typedef struct packed {
    logic [63:0]        n2a;
    logic [63:0]        d2a;
    logic [63:0]        n2b;
    logic [63:0]        d2b;
    logic               bnz;
    logic signed [33:0] n1;
    logic signed [33:0] n3;
    logic signed [15:0] hy;
    logic [15:0]        arx;
    logic               l1nz;
    logic               l2nz;
  } s3_t;

  typedef struct packed {
    logic signed [15:0] hy;
    logic [15:0]        arx;
    logic signed [33:0] n1;
    logic signed [33:0] n3;
    logic               ok1;
    logic               ok3;
  } side_t;

  // Configuration registers.
  logic [LinkW-1:0] l1_q;
  logic [LinkW-1:0] l2_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q <= UpperLinkReset;
      l2_q <= LowerLinkReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegUpperLink: l1_q <= cfg_data_i[LinkW-1:0];
        RegLowerLink: l2_q <= cfg_data_i[LinkW-1:0];
        default: ;
      endcase
    end
  end

  // Flow control.
  logic                 en;
  logic                 skid_v_q;
  logic                 out_v_q;
  logic [PipeDepth-1:0] vld_q;
  logic                 pv;
  logic                 out_take;

  assign en         = !skid_v_q;
  assign in_ready_o = en;
  assign pv         = vld_q[PipeDepth-1];
  assign out_take   = out_ready_i || !out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeDepth-2:0], in_valid_i};
    end
  end

  // Stage 1: squares.
  logic signed [31:0] rx2_full;
  logic signed [31:0] hy2_full;
  logic signed [16:0] rx_neg;
  s1_t                s1_d;
  s1_t                s1_q;

  always_comb begin
    rx2_full  = in_data_i.reach_distance * in_data_i.reach_distance;
    hy2_full  = in_data_i.height_offset * in_data_i.height_offset;
    rx_neg    = -{in_data_i.reach_distance[15], in_data_i.reach_distance};
    s1_d.rx2  = rx2_full[30:0];
    s1_d.hy2  = hy2_full[30:0];
    s1_d.l1sq = l1_q * l1_q;
    s1_d.l2sq = l2_q * l2_q;
    s1_d.hy   = in_data_i.height_offset;
    s1_d.arx  = in_data_i.reach_distance[15] ? rx_neg[15:0] : in_data_i.reach_distance;
    s1_d.l1nz = (l1_q != '0);
    s1_d.l2nz = (l2_q != '0);
  end

  // Stage 2: squared distance and the two law-of-cosines numerators.
  s2_t s2_d;
  s2_t s2_q;

  always_comb begin
    s2_d.b2   = {1'b0, s1_q.rx2} + {1'b0, s1_q.hy2};
    s2_d.l1sq = s1_q.l1sq;
    s2_d.l2sq = s1_q.l2sq;
    s2_d.n1   = $signed({2'b00, s2_d.b2}) + $signed({4'b0000, s1_q.l1sq})
              - $signed({4'b0000, s1_q.l2sq});
    s2_d.n3   = $signed({4'b0000, s1_q.l1sq}) + $signed({4'b0000, s1_q.l2sq})
              - $signed({2'b00, s2_d.b2});
    s2_d.hy   = s1_q.hy;
    s2_d.arx  = s1_q.arx;
    s2_d.l1nz = s1_q.l1nz;
    s2_d.l2nz = s1_q.l2nz;
  end

  // Stage 3: numerator squared against the squared denominator.
  logic signed [33:0] neg1;
  logic signed [33:0] neg3;
  logic [31:0]        an1;
  logic [31:0]        an3;
  logic [61:0]        pa;
  logic [59:0]        pb;
  s3_t                s3_d;
  s3_t                s3_q;

  always_comb begin
    neg1      = -s2_q.n1;
    neg3      = -s2_q.n3;
    an1       = s2_q.n1[33] ? neg1[31:0] : s2_q.n1[31:0];
    an3       = s2_q.n3[33] ? neg3[31:0] : s2_q.n3[31:0];
    pa        = {30'd0, s2_q.b2} * {32'd0, s2_q.l1sq};
    pb        = {30'd0, s2_q.l1sq} * {30'd0, s2_q.l2sq};
    s3_d.n2a  = {32'd0, an1} * {32'd0, an1};
    s3_d.d2a  = {pa, 2'b00};
    s3_d.n2b  = {32'd0, an3} * {32'd0, an3};
    s3_d.d2b  = {2'b00, pb, 2'b00};
    s3_d.bnz  = (s2_q.b2 != '0);
    s3_d.n1   = s2_q.n1;
    s3_d.n3   = s2_q.n3;
    s3_d.hy   = s2_q.hy;
    s3_d.arx  = s2_q.arx;
    s3_d.l1nz = s2_q.l1nz;
    s3_d.l2nz = s2_q.l2nz;
  end

  // Stage 4: range check and square-root operands.
  logic       ok1_c;
  logic       ok3_c;
  tlik_sqrt_t sq1_d;
  tlik_sqrt_t sq3_d;
  tlik_sqrt_t sq1_q;
  tlik_sqrt_t sq3_q;
  side_t      side_d;

  always_comb begin
    ok1_c       = s3_q.bnz && s3_q.l1nz && (s3_q.n2a <= s3_q.d2a);
    ok3_c       = s3_q.bnz && s3_q.l1nz && s3_q.l2nz && (s3_q.n2b <= s3_q.d2b);
    sq1_d.rem   = ok1_c ? (s3_q.d2a - s3_q.n2a) : '0;
    sq1_d.root  = '0;
    sq3_d.rem   = ok3_c ? (s3_q.d2b - s3_q.n2b) : '0;
    sq3_d.root  = '0;
    side_d.hy   = s3_q.hy;
    side_d.arx  = s3_q.arx;
    side_d.n1   = s3_q.n1;
    side_d.n3   = s3_q.n3;
    side_d.ok1  = ok1_c;
    side_d.ok3  = ok3_c;
  end

  // Side data runs alongside the square-root cells, flags alongside the angle units.
  side_t      side_q [SqrtSteps+1];
  logic [1:0] ok_q   [AngLat];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q      <= s1_d;
      s2_q      <= s2_d;
      s3_q      <= s3_d;
      sq1_q     <= sq1_d;
      sq3_q     <= sq3_d;
      side_q[0] <= side_d;
      for (int k = 1; k <= SqrtSteps; k++) begin
        side_q[k] <= side_q[k-1];
      end
      ok_q[0] <= {side_q[SqrtSteps].ok1, side_q[SqrtSteps].ok3};
      for (int k = 1; k < AngLat; k++) begin
        ok_q[k] <= ok_q[k-1];
      end
    end
  end

  tlik_sqrt_t sq1 [SqrtSteps+1];
  tlik_sqrt_t sq3 [SqrtSteps+1];

  assign sq1[0] = sq1_q;
  assign sq3[0] = sq3_q;

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    tlik_sqrt_cell #(.Idx(k)) u_sqrt_up (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (sq1[k]),
      .q_o   (sq1[k+1])
    );
    tlik_sqrt_cell #(.Idx(k)) u_sqrt_lo (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (sq3[k]),
      .q_o   (sq3[k+1])
    );
  end

  // Three angles: foot direction, upper triangle corner, knee corner.
  logic [AngW-1:0] za;
  logic [AngW-1:0] zb;
  logic [AngW-1:0] zc;

  tlik_angle u_ang_dir (
    .clk_i (clk_i),
    .en_i  (en),
    .px_i  ($signed({{(VecXW-16){side_q[SqrtSteps].hy[15]}}, side_q[SqrtSteps].hy})),
    .py_i  ({{(VecYW-16){1'b0}}, side_q[SqrtSteps].arx}),
    .ang_o (za)
  );

  tlik_angle u_ang_up (
    .clk_i (clk_i),
    .en_i  (en),
    .px_i  (side_q[SqrtSteps].n1),
    .py_i  ({1'b0, sq1[SqrtSteps].root[31:0]}),
    .ang_o (zb)
  );

  tlik_angle u_ang_lo (
    .clk_i (clk_i),
    .en_i  (en),
    .px_i  (side_q[SqrtSteps].n3),
    .py_i  ({1'b0, sq3[SqrtSteps].root[31:0]}),
    .ang_o (zc)
  );

  // Final stage: whole degrees and the open-interval check.
  logic [AngW:0]    up_sum;
  logic [8:0]       up_deg;
  logic [7:0]       lo_t;
  logic             up_ok;
  logic             lo_ok;
  tlik_out_t        fin_d;
  tlik_out_t        fin_q;

  always_comb begin
    up_sum = {1'b0, za} + {1'b0, zb};
    up_deg = up_sum[AngW:AngFrac];
    lo_t   = zc[AngW-1:AngFrac];
    up_ok  = ok_q[AngLat-1][1] && (up_deg != '0) && (up_deg < {1'b0, DegMax});
    lo_ok  = ok_q[AngLat-1][0] && (lo_t != '0) && (lo_t < DegMax);
    fin_d.upper_joint_deg = up_ok ? up_deg[7:0] : '0;
    fin_d.upper_valid     = up_ok;
    fin_d.lower_joint_deg = lo_ok ? (DegMax - lo_t) : '0;
    fin_d.lower_valid     = lo_ok;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_q <= fin_d;
    end
  end

  // Output register with a one-entry skid buffer.
  tlik_out_t out_q;
  tlik_out_t skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_take) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= pv;
      end
    end else if (pv && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      out_q <= skid_v_q ? skid_q : fin_q;
    end else if (pv && en) begin
      skid_q <= fin_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_valid_o)
    else $error("skid entry holds a result while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_valid_o && !out_ready_i))
    else $error("skid entry filled without a stalled output");

  a_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.upper_valid) |-> (out_data_o.upper_joint_deg == 8'd0))
    else $error("invalid upper angle is not zero");

  a_lower_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.lower_valid) |->
      (out_data_o.lower_joint_deg != 8'd0 && out_data_o.lower_joint_deg < 8'd180))
    else $error("valid lower angle outside the open range");
`endif

endmodule
